// ===== hdl/srfim_pkg.sv =====
// Shared constants, codes and types for the segmented register file with indirect map.
package srfim_pkg;

   // Default sizes
   localparam int STORE_BYTES_DEF      = 256;
   localparam int MAX_ACCESS_BYTES_DEF = 4;

   // Fixed field widths
   localparam int ADDR_W   = 16;
   localparam int LEN_W    = 9;
   localparam int OFF_W    = 10;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Segments: first data, second data, map (also the tie order)
   localparam int SEG_COUNT  = 3;
   localparam int SEG_FIRST  = 0;
   localparam int SEG_SECOND = 1;
   localparam int SEG_MAP    = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_DATA_START  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_DATA_LENGTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_DATA_START = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_DATA_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_START      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_START         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_LENGTH        = 3'd6;

   // Access function codes
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // One segment in lookup order
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  len;
      logic [OFF_W-1:0]  off;
   } seg_type;

   // Decoded layout, segments sorted by start
   typedef struct packed {
      seg_type [SEG_COUNT-1:0] seg;
      logic [ADDR_W-1:0]       window_start;
      logic [7:0]              entries;
      logic [OFF_W-1:0]        map_off;
      logic                    oversize;
   } layout_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_FAIL,
      OP_MAP_LO,
      OP_MAP_HI,
      OP_RESOLVE,
      OP_DIRECT,
      OP_ACCESS,
      OP_GATHER,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic oversize;
      logic empty;
      logic addr_over;
      logic in_window;
      logic loc_hit;
      logic is_write;
      logic last;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== hdl/segmented_register_file_indirect_map.sv =====
// Each byte is reached directly or through the map, which adds two store reads for the
// map entry; a read byte also takes a gather step that a write byte does not.
// One access at a time, set by the single-port backing store that serves map
// reads and data accesses in turn; the next request is taken in the cycle after the result
// is loaded, and loading holds while an earlier result still waits.
// Reset: synchronous; clears the configuration, then sweeps every store byte to zero
// with req_ready low (config writes are still taken).
module segmented_register_file_indirect_map #(
   parameter int STORE_BYTES      = srfim_pkg::STORE_BYTES_DEF,
   parameter int MAX_ACCESS_BYTES = srfim_pkg::MAX_ACCESS_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [srfim_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srfim_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  logic [srfim_pkg::ADDR_W-1:0]      req_start_address,
   input  logic [srfim_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic [srfim_pkg::DATA_W-1:0]      req_write_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [srfim_pkg::DATA_W-1:0]      rsp_read_value,
   output logic                              rsp_access_ok
);

   srfim_pkg::layout_type layout;
   srfim_pkg::cmd_type    cmd;
   srfim_pkg::stat_type   stat;

   // Configuration and layout
   srfim_layout #(
      .STORE_BYTES (STORE_BYTES)
   ) u_layout (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .layout    (layout)
   );

   // Sequencer
   srfim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store and result path
   srfim_dpath #(
      .STORE_BYTES      (STORE_BYTES),
      .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_func          (req_func),
      .req_start_address (req_start_address),
      .req_byte_count    (req_byte_count),
      .req_write_value   (req_write_value),
      .layout            (layout),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_access_ok     (rsp_access_ok)
   );

endmodule

// ===== hdl/srfim_layout.sv =====
// Configuration registers and the sorted segment layout derived from them.
module srfim_layout #(
   parameter int STORE_BYTES = srfim_pkg::STORE_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srfim_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [srfim_pkg::CSR_DATA_W-1:0]     csr_data,
   output srfim_pkg::layout_type                layout
);

   logic [srfim_pkg::ADDR_W-1:0] first_start_ff, second_start_ff, window_start_ff, map_start_ff;
   logic [srfim_pkg::LEN_W-1:0]  first_len_ff, second_len_ff, map_len_ff;

   logic [srfim_pkg::ADDR_W-1:0] st   [srfim_pkg::SEG_COUNT];
   logic [srfim_pkg::LEN_W-1:0]  len  [srfim_pkg::SEG_COUNT];
   logic [srfim_pkg::OFF_W-1:0]  off  [srfim_pkg::SEG_COUNT];
   logic [1:0]                   rank [srfim_pkg::SEG_COUNT];
   logic [srfim_pkg::OFF_W:0]    total;
   srfim_pkg::layout_type        layout_in;
   srfim_pkg::layout_type        layout_ff;

   assign csr_ready = 1'b1;

   // Take register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         first_start_ff  <= '0;
         first_len_ff    <= '0;
         second_start_ff <= '0;
         second_len_ff   <= '0;
         window_start_ff <= '0;
         map_start_ff    <= '0;
         map_len_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            srfim_pkg::REG_FIRST_DATA_START:  first_start_ff  <= csr_data;
            srfim_pkg::REG_FIRST_DATA_LENGTH: first_len_ff    <= csr_data[srfim_pkg::LEN_W-1:0];
            srfim_pkg::REG_SECOND_DATA_START: second_start_ff <= csr_data;
            srfim_pkg::REG_SECOND_DATA_LENGTH: second_len_ff  <= csr_data[srfim_pkg::LEN_W-1:0];
            srfim_pkg::REG_WINDOW_START:      window_start_ff <= csr_data;
            srfim_pkg::REG_MAP_START:         map_start_ff    <= csr_data;
            srfim_pkg::REG_MAP_LENGTH:        map_len_ff      <= csr_data[srfim_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign st[srfim_pkg::SEG_FIRST]   = first_start_ff;
   assign st[srfim_pkg::SEG_SECOND]  = second_start_ff;
   assign st[srfim_pkg::SEG_MAP]     = map_start_ff;
   assign len[srfim_pkg::SEG_FIRST]  = first_len_ff;
   assign len[srfim_pkg::SEG_SECOND] = second_len_ff;
   assign len[srfim_pkg::SEG_MAP]    = map_len_ff;

   // Rank each segment by start (ties keep fixed order) and carve the store
   always_comb begin
      for (int k = 0; k < srfim_pkg::SEG_COUNT; k++) begin
         rank[k] = 2'd0;
         off[k]  = '0;
         for (int j = 0; j < srfim_pkg::SEG_COUNT; j++) begin
            if (j != k && (st[j] < st[k] || (st[j] == st[k] && j < k))) begin
               rank[k] = rank[k] + 2'd1;
               off[k]  = off[k] + srfim_pkg::OFF_W'(len[j]);
            end
         end
      end
   end

   // Full sum of the three lengths, one bit wider so it cannot wrap
   assign total = (srfim_pkg::OFF_W + 1)'(first_len_ff)
                + (srfim_pkg::OFF_W + 1)'(second_len_ff)
                + (srfim_pkg::OFF_W + 1)'(map_len_ff);

   // Place segments in lookup order
   always_comb begin
      layout_in = '0;
      for (int r = 0; r < srfim_pkg::SEG_COUNT; r++) begin
         for (int k = 0; k < srfim_pkg::SEG_COUNT; k++) begin
            if (rank[k] == 2'(r)) begin
               layout_in.seg[r].start = st[k];
               layout_in.seg[r].len   = len[k];
               layout_in.seg[r].off   = off[k];
            end
         end
      end
      layout_in.window_start = window_start_ff;
      layout_in.entries      = 8'(map_len_ff >> 1);
      layout_in.map_off      = off[srfim_pkg::SEG_MAP];
      layout_in.oversize     = 32'(total) > 32'(STORE_BYTES);
   end

   // Hold the decoded layout
   always_ff @(posedge clock) begin
      layout_ff <= layout_in;
   end

   assign layout = layout_ff;

endmodule

// ===== hdl/srfim_dpath.sv =====
// Datapath: backing store, address resolution, segment lookup and result register.
module srfim_dpath #(
   parameter int STORE_BYTES      = srfim_pkg::STORE_BYTES_DEF,
   parameter int MAX_ACCESS_BYTES = srfim_pkg::MAX_ACCESS_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_func,
   input  logic [srfim_pkg::ADDR_W-1:0]      req_start_address,
   input  logic [srfim_pkg::COUNT_W-1:0]     req_byte_count,
   input  logic [srfim_pkg::DATA_W-1:0]      req_write_value,
   input  srfim_pkg::layout_type             layout,
   input  srfim_pkg::cmd_type                cmd,
   output srfim_pkg::stat_type               stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [srfim_pkg::DATA_W-1:0]      rsp_read_value,
   output logic                              rsp_access_ok
);

   localparam int IW = $clog2(STORE_BYTES);
   localparam int PW = (IW > srfim_pkg::OFF_W) ? IW : srfim_pkg::OFF_W;
   localparam int CW = $clog2(MAX_ACCESS_BYTES + 1);
   localparam logic [CW-1:0] COUNT_MAX   = CW'(MAX_ACCESS_BYTES);
   localparam logic [31:0]   STORE_LIMIT = 32'(STORE_BYTES);
   localparam logic [IW-1:0] LAST_ENTRY  = IW'(STORE_BYTES - 1);

   // Backing store
   logic [7:0] mem [STORE_BYTES];
   logic [IW-1:0] mem_addr;
   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [7:0]    rd_byte_ff;

   // Item and progress registers
   logic                           is_write_ff;
   logic [srfim_pkg::ADDR_W-1:0]   base_ff;
   logic [CW-1:0]                  count_ff;
   logic [srfim_pkg::DATA_W-1:0]   wdata_ff;
   logic [CW-1:0]                  pos_ff;
   logic [srfim_pkg::DATA_W-1:0]   acc_ff;
   logic                           ok_ff;
   logic [7:0]                     lo_ff;
   logic                           map_ok_ff;
   logic [srfim_pkg::ADDR_W-1:0]   resolved_ff;
   logic [IW-1:0]                  clr_ptr_ff;
   logic                           rsp_valid_ff;
   logic [srfim_pkg::DATA_W-1:0]   rsp_read_value_ff;
   logic                           rsp_access_ok_ff;

   logic [CW-1:0]                  count_in;
   logic [srfim_pkg::ADDR_W:0]     addr_cur;
   logic [srfim_pkg::ADDR_W:0]     win_end;
   logic                           in_window;
   logic [7:0]                     win_off;
   logic [PW-1:0]                  map_lo_p;
   logic [PW-1:0]                  map_hi_p;
   logic                           loc_hit;
   logic [PW-1:0]                  loc_p;
   logic                           loc_ok;
   logic [srfim_pkg::DATA_W-1:0]   wshift;
   logic [7:0]                     wbyte;
   logic [srfim_pkg::DATA_W-1:0]   gather_val;
   logic                           pos_low;

   // Clamp the byte count
   assign count_in = ({1'b0, req_byte_count} > 4'(MAX_ACCESS_BYTES)) ?
                     COUNT_MAX : CW'(req_byte_count);

   // Current byte address and indirect window test
   assign addr_cur  = {1'b0, base_ff} + (srfim_pkg::ADDR_W + 1)'(pos_ff);
   assign win_end   = {1'b0, layout.window_start} + (srfim_pkg::ADDR_W + 1)'(layout.entries);
   assign in_window = (addr_cur >= {1'b0, layout.window_start}) && (addr_cur < win_end);
   assign win_off   = 8'(addr_cur - {1'b0, layout.window_start});
   assign map_lo_p  = PW'(layout.map_off) + PW'({win_off, 1'b0});
   assign map_hi_p  = map_lo_p + PW'(1);

   // Segment lookup: lowest start wins
   always_comb begin
      loc_hit = 1'b0;
      loc_p   = '0;
      for (int r = srfim_pkg::SEG_COUNT - 1; r >= 0; r--) begin
         if ({1'b0, resolved_ff} >= {1'b0, layout.seg[r].start} &&
             {1'b0, resolved_ff} < ({1'b0, layout.seg[r].start} +
                                    (srfim_pkg::ADDR_W + 1)'(layout.seg[r].len))) begin
            loc_hit = 1'b1;
            loc_p   = PW'(layout.seg[r].off) + PW'(8'(resolved_ff - layout.seg[r].start));
         end
      end
   end

   assign loc_ok = loc_hit && (32'(loc_p) < STORE_LIMIT);

   // Byte lanes of the write and read data
   assign pos_low    = 32'(pos_ff) < 32'd4;
   assign wshift     = wdata_ff >> {pos_ff, 3'b000};
   assign wbyte      = pos_low ? wshift[7:0] : 8'd0;
   assign gather_val = pos_low ? (32'(rd_byte_ff) << {pos_ff, 3'b000}) : '0;

   // Select the store port
   always_comb begin
      mem_addr  = loc_p[IW-1:0];
      mem_we    = 1'b0;
      mem_wdata = wbyte;
      unique case (cmd.op)
         srfim_pkg::OP_CLEAR: begin
            mem_addr  = clr_ptr_ff;
            mem_we    = 1'b1;
            mem_wdata = 8'd0;
         end
         srfim_pkg::OP_MAP_LO: mem_addr = map_lo_p[IW-1:0];
         srfim_pkg::OP_MAP_HI: mem_addr = map_hi_p[IW-1:0];
         srfim_pkg::OP_ACCESS: mem_we   = is_write_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_byte_ff <= mem[mem_addr];
   end

   // Control registers: clearing pointer and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == srfim_pkg::OP_CLEAR) begin
            clr_ptr_ff <= clr_ptr_ff + IW'(1);
         end
         if (cmd.op == srfim_pkg::OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         srfim_pkg::OP_LOAD: begin
            is_write_ff <= (req_func == srfim_pkg::FUNC_WRITE);
            base_ff     <= req_start_address;
            count_ff    <= count_in;
            wdata_ff    <= req_write_value;
            pos_ff      <= '0;
            acc_ff      <= '0;
            ok_ff       <= 1'b1;
         end
         srfim_pkg::OP_FAIL: ok_ff <= 1'b0;
         srfim_pkg::OP_MAP_LO: map_ok_ff <= 32'(map_lo_p) < STORE_LIMIT;
         srfim_pkg::OP_MAP_HI: begin
            lo_ff     <= map_ok_ff ? rd_byte_ff : 8'd0;
            map_ok_ff <= 32'(map_hi_p) < STORE_LIMIT;
         end
         srfim_pkg::OP_RESOLVE: resolved_ff <= {(map_ok_ff ? rd_byte_ff : 8'd0), lo_ff};
         srfim_pkg::OP_DIRECT:  resolved_ff <= addr_cur[srfim_pkg::ADDR_W-1:0];
         srfim_pkg::OP_ACCESS: begin
            if (is_write_ff) begin
               pos_ff <= pos_ff + CW'(1);
            end
         end
         srfim_pkg::OP_GATHER: begin
            acc_ff <= acc_ff | gather_val;
            pos_ff <= pos_ff + CW'(1);
         end
         srfim_pkg::OP_FINISH: begin
            rsp_read_value_ff <= acc_ff;
            rsp_access_ok_ff  <= ok_ff;
         end
         default: ;
      endcase
   end

   // Status to the controller
   always_comb begin
      stat.clear_last = (clr_ptr_ff == LAST_ENTRY);
      stat.oversize   = layout.oversize;
      stat.empty      = (count_ff == '0);
      stat.addr_over  = addr_cur[srfim_pkg::ADDR_W];
      stat.in_window  = in_window;
      stat.loc_hit    = loc_ok;
      stat.is_write   = is_write_ff;
      stat.last       = ((pos_ff + CW'(1)) == count_ff);
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_access_ok  = rsp_access_ok_ff;

endmodule

// ===== hdl/srfim_ctrl.sv =====
// Controller: sequences store clearing and the byte-by-byte access.
module srfim_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srfim_pkg::stat_type   stat,
   output srfim_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_BYTE,
      ST_MAP_HI,
      ST_RESOLVE,
      ST_LOCATE,
      ST_GATHER,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   // Next state and datapath operation
   always_comb begin
      state_in = state_ff;
      cmd.op   = srfim_pkg::OP_IDLE;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = srfim_pkg::OP_CLEAR;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.op   = srfim_pkg::OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.oversize) begin
               cmd.op   = srfim_pkg::OP_FAIL;
               state_in = ST_FINISH;
            end else if (stat.empty) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_BYTE;
            end
         end
         ST_BYTE: begin
            if (stat.addr_over) begin
               cmd.op   = srfim_pkg::OP_FAIL;
               state_in = ST_FINISH;
            end else if (stat.in_window) begin
               cmd.op   = srfim_pkg::OP_MAP_LO;
               state_in = ST_MAP_HI;
            end else begin
               cmd.op   = srfim_pkg::OP_DIRECT;
               state_in = ST_LOCATE;
            end
         end
         ST_MAP_HI: begin
            cmd.op   = srfim_pkg::OP_MAP_HI;
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            cmd.op   = srfim_pkg::OP_RESOLVE;
            state_in = ST_LOCATE;
         end
         ST_LOCATE: begin
            if (!stat.loc_hit) begin
               cmd.op   = srfim_pkg::OP_FAIL;
               state_in = ST_FINISH;
            end else begin
               cmd.op = srfim_pkg::OP_ACCESS;
               if (!stat.is_write) state_in = ST_GATHER;
               else if (stat.last) state_in = ST_FINISH;
               else                state_in = ST_BYTE;
            end
         end
         ST_GATHER: begin
            cmd.op   = srfim_pkg::OP_GATHER;
            state_in = stat.last ? ST_FINISH : ST_BYTE;
         end
         ST_FINISH: begin
            // hold while the previous result still waits
            if (!stat.rsp_busy) begin
               cmd.op   = srfim_pkg::OP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and the registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// ===== dv/tb.sv =====
// Testbench for the segmented register file with indirect address map.
`timescale 1ns / 1ps

module tb;
   import srfim_pkg::*;

   localparam int STORE_SIZE    = STORE_BYTES_DEF;
   localparam int ACCESS_MAX    = MAX_ACCESS_BYTES_DEF;
   localparam int LIMIT_CYCLES  = 300000;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 52;
   localparam int HOLD_ITEMS    = 30;
   localparam int REPORT_CAP    = 100;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic [DATA_W-1:0] read_value;
      logic              access_ok;
   } access_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_func = FUNC_READ;
   logic [ADDR_W-1:0]     req_start_address = '0;
   logic [COUNT_W-1:0]    req_byte_count = '0;
   logic [DATA_W-1:0]     req_write_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_W-1:0]     rsp_read_value;
   logic                  rsp_access_ok;

   // Mirror of the configuration and the backing store
   logic [ADDR_W-1:0] cfg_first_start, cfg_second_start, cfg_window_start, cfg_map_start;
   logic [LEN_W-1:0]  cfg_first_len, cfg_second_len, cfg_map_len;
   logic [7:0]        store_image [STORE_SIZE];

   // Current carving of the store, segments in lookup order
   int unsigned lay_start [SEG_COUNT];
   int unsigned lay_len   [SEG_COUNT];
   int unsigned lay_off   [SEG_COUNT];
   int unsigned lay_map_off;

   access_result_type awaited_results [$];
   int             mismatches  = 0;
   int             cycle_count = 0;
   int             sender_idle_pct    = 0;
   int             receiver_stall_pct = 0;
   int             hold_left = 0;

   segmented_register_file_indirect_map dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_start_address (req_start_address),
      .req_byte_count    (req_byte_count),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_value    (rsp_read_value),
      .rsp_access_ok     (rsp_access_ok)
   );

   always #1 clock = ~clock;

   // Sort the segments by start, ties in fixed order, and carve the store
   function automatic int unsigned carve_layout();
      int unsigned st [SEG_COUNT];
      int unsigned ln [SEG_COUNT];
      int          kind [SEG_COUNT];
      int unsigned ts, tl, off;
      int          tk, j, k;
      st[SEG_FIRST]  = cfg_first_start;
      st[SEG_SECOND] = cfg_second_start;
      st[SEG_MAP]    = cfg_map_start;
      ln[SEG_FIRST]  = cfg_first_len;
      ln[SEG_SECOND] = cfg_second_len;
      ln[SEG_MAP]    = cfg_map_len;
      for (k = 0; k < SEG_COUNT; k++) kind[k] = k;
      for (k = 1; k < SEG_COUNT; k++) begin
         j = k;
         while (j > 0 && st[j] < st[j-1]) begin
            ts = st[j];   st[j]   = st[j-1];   st[j-1]   = ts;
            tl = ln[j];   ln[j]   = ln[j-1];   ln[j-1]   = tl;
            tk = kind[j]; kind[j] = kind[j-1]; kind[j-1] = tk;
            j--;
         end
      end
      off = 0;
      for (k = 0; k < SEG_COUNT; k++) begin
         lay_start[k] = st[k];
         lay_len[k]   = ln[k];
         lay_off[k]   = off;
         if (kind[k] == SEG_MAP) lay_map_off = off;
         off += ln[k];
      end
      return off;
   endfunction

   // First segment holding the address wins; the store index must fit
   function automatic bit locate_byte(input int unsigned addr, output int unsigned idx);
      int k;
      idx = 0;
      for (k = 0; k < SEG_COUNT; k++) begin
         if (addr >= lay_start[k] && addr < lay_start[k] + lay_len[k]) begin
            idx = lay_off[k] + addr - lay_start[k];
            return idx < STORE_SIZE;
         end
      end
      return 1'b0;
   endfunction

   // Swap a window address for its little-endian map entry
   function automatic int unsigned window_target(input int unsigned addr);
      int unsigned entries, p, lo, hi;
      entries = cfg_map_len / 2;
      if (addr >= cfg_window_start && addr < cfg_window_start + entries) begin
         p  = lay_map_off + 2 * (addr - cfg_window_start);
         lo = (p < STORE_SIZE) ? store_image[p] : 0;
         hi = (p + 1 < STORE_SIZE) ? store_image[p+1] : 0;
         return lo | (hi << 8);
      end
      return addr;
   endfunction

   // Carry out one access on the mirror and return its result
   function automatic access_result_type emulate_access(input logic func,
                                                        input logic [ADDR_W-1:0] start,
                                                        input logic [COUNT_W-1:0] count,
                                                        input logic [DATA_W-1:0] wv);
      access_result_type r;
      int unsigned    n, i, a, idx;
      bit             hit;
      r.read_value = '0;
      r.access_ok  = 1'b1;
      n = (count > ACCESS_MAX) ? ACCESS_MAX : count;
      if (carve_layout() > STORE_SIZE) begin
         r.access_ok = 1'b0;
         n = 0;
      end
      for (i = 0; i < n; i++) begin
         a = start + i;
         if (a > 16'hFFFF) hit = 1'b0;
         else hit = locate_byte(window_target(a), idx);
         if (!hit) begin
            r.access_ok = 1'b0;
            break;
         end
         if (func == FUNC_WRITE) store_image[idx] = wv[8*i +: 8];
         else r.read_value[8*i +: 8] = store_image[idx];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (mismatches < REPORT_CAP)
         $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Check each result transfer against the oldest awaited one
   always @(posedge clock) begin : check_results
      access_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unawaited result", rsp_read_value, '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_read_value !== want.read_value)
               report_mismatch("read_value", rsp_read_value, want.read_value);
            if (rsp_access_ok !== want.access_ok)
               report_mismatch("access_ok", rsp_access_ok, want.access_ok);
         end
      end
   end

   // Drive result ready: long hold-off first, else random stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Write one register and mirror it on the transfer
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         REG_FIRST_DATA_START:   cfg_first_start  = data;
         REG_FIRST_DATA_LENGTH:  cfg_first_len    = data[LEN_W-1:0];
         REG_SECOND_DATA_START:  cfg_second_start = data;
         REG_SECOND_DATA_LENGTH: cfg_second_len   = data[LEN_W-1:0];
         REG_WINDOW_START:       cfg_window_start = data;
         REG_MAP_START:          cfg_map_start    = data;
         REG_MAP_LENGTH:         cfg_map_len      = data[LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_layout(input logic [ADDR_W-1:0] fs, input logic [LEN_W-1:0] fl,
                                 input logic [ADDR_W-1:0] ss, input logic [LEN_W-1:0] sl,
                                 input logic [ADDR_W-1:0] ws, input logic [ADDR_W-1:0] ms,
                                 input logic [LEN_W-1:0] ml);
      write_csr(REG_FIRST_DATA_START, fs);
      write_csr(REG_FIRST_DATA_LENGTH, CSR_DATA_W'(fl));
      write_csr(REG_SECOND_DATA_START, ss);
      write_csr(REG_SECOND_DATA_LENGTH, CSR_DATA_W'(sl));
      write_csr(REG_WINDOW_START, ws);
      write_csr(REG_MAP_START, ms);
      write_csr(REG_MAP_LENGTH, CSR_DATA_W'(ml));
   endtask

   // Offer one access, record its result on the transfer; valid stays up
   task automatic issue_access(input logic func, input logic [ADDR_W-1:0] addr,
                               input logic [COUNT_W-1:0] count, input logic [DATA_W-1:0] value);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_start_address <= addr;
      req_byte_count    <= count;
      req_write_value   <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_results.insert(awaited_results.size(), emulate_access(func, addr, count, value));
      @(negedge clock);
   endtask

   // Drop valid and let every awaited result arrive
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // Address near a region: a little before, inside, a little past
   function automatic logic [ADDR_W-1:0] near(input logic [ADDR_W-1:0] start, input int len);
      return ADDR_W'(start + $urandom_range(0, len + 3) - 2);
   endfunction

   // Map entry content, mostly aimed into a segment
   function automatic logic [ADDR_W-1:0] entry_target();
      int sel;
      sel = $urandom_range(99);
      if (sel < 42) return ADDR_W'(cfg_first_start + $urandom_range(0, cfg_first_len));
      if (sel < 84) return ADDR_W'(cfg_second_start + $urandom_range(0, cfg_second_len));
      if (sel < 94) return ADDR_W'(cfg_map_start + $urandom_range(0, cfg_map_len));
      return ADDR_W'($urandom_range(0, 16'hFFFF));
   endfunction

   // One random access aimed at the current layout
   task automatic random_access();
      int                 sel, c;
      logic               func;
      logic [ADDR_W-1:0]  addr;
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  value;
      sel   = $urandom_range(99);
      func  = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
      value = $urandom();
      if ($urandom_range(9) == 0) begin
         c = $urandom_range(5, 8);
         count = (c == 8) ? '0 : COUNT_W'(c);
      end else begin
         count = COUNT_W'($urandom_range(1, ACCESS_MAX));
      end
      if (sel < 28) addr = near(cfg_first_start, cfg_first_len);
      else if (sel < 48) addr = near(cfg_second_start, cfg_second_len);
      else if (sel < 72) addr = near(cfg_window_start, cfg_map_len / 2);
      else if (sel < 88) begin
         // fill map entries with useful targets
         addr = ADDR_W'(cfg_map_start + 2 * $urandom_range(0, cfg_map_len / 2));
         if ($urandom_range(3) != 0) begin
            func  = FUNC_WRITE;
            value = {entry_target(), entry_target()};
            count = $urandom_range(1) ? 3'd2 : 3'd4;
         end
      end else begin
         addr = ADDR_W'($urandom_range(0, 16'hFFFF));
      end
      issue_access(func, addr, count, value);
   endtask

   // Clustered layout so that segments and window overlap often
   task automatic random_layout();
      logic [ADDR_W-1:0] base;
      int                l1, l2, lm;
      base = ADDR_W'($urandom_range(0, 16'hFFFF));
      if ($urandom_range(7) == 0) begin
         l1 = $urandom_range(96, 256);
         l2 = $urandom_range(96, 256);
         lm = $urandom_range(0, 64);
      end else begin
         l1 = $urandom_range(0, 120);
         l2 = $urandom_range(0, 80);
         lm = $urandom_range(0, 57);
      end
      program_layout(ADDR_W'(base + $urandom_range(0, 383)), LEN_W'(l1),
                     ADDR_W'(base + $urandom_range(0, 383)), LEN_W'(l2),
                     ADDR_W'(base + $urandom_range(0, 383)),
                     ADDR_W'(base + $urandom_range(0, 383)), LEN_W'(lm));
   endtask

   // Empty layout after reset; unknown register ignored; zero count passes
   task automatic test_cleared_store();
      write_csr(REG_UNUSED, 16'hFFFF);
      issue_access(FUNC_READ, 16'h0000, 3'd1, 32'h0);
      issue_access(FUNC_WRITE, 16'hFFFF, 3'd0, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   // Plain segments: full words, partial failure at a segment end, clamped count
   task automatic test_direct_segments();
      program_layout(16'h0010, 9'd64, 16'h0100, 9'd32, 16'h0200, 16'h0300, 9'd16);
      issue_access(FUNC_WRITE, 16'h0010, 3'd4, 32'hFFFF_FFFF);
      issue_access(FUNC_READ, 16'h0010, 3'd4, 32'h0);
      issue_access(FUNC_WRITE, 16'h004E, 3'd4, 32'h4433_2211);
      issue_access(FUNC_READ, 16'h004E, 3'd4, 32'h0);
      issue_access(FUNC_READ, 16'h0100, 3'd4, 32'h0);
      issue_access(FUNC_WRITE, 16'h011F, 3'd5, 32'h0);
      issue_access(FUNC_READ, 16'h0010, 3'd6, 32'h0);
      issue_access(FUNC_READ, 16'h0010, 3'd7, 32'h0);
      wait_idle();
   endtask

   // Window through the map; an entry that lands in the window is not resolved again
   task automatic test_indirect_window();
      issue_access(FUNC_WRITE, 16'h0300, 3'd4, {16'h0101, 16'h0012});
      issue_access(FUNC_WRITE, 16'h0304, 3'd4, {16'h0200, 16'hFFFF});
      issue_access(FUNC_WRITE, 16'h0200, 3'd2, 32'h0000_BEEF);
      issue_access(FUNC_READ, 16'h0200, 3'd4, 32'h0);
      issue_access(FUNC_READ, 16'h0203, 3'd1, 32'h0);
      wait_idle();
   endtask

   // Segment clipped at the top of the address space; overflow past it fails
   task automatic test_address_top();
      program_layout(16'hFFFE, 9'd200, 16'h0000, 9'd4, 16'hFFF0, 16'h0004, 9'd4);
      issue_access(FUNC_WRITE, 16'hFFFE, 3'd4, 32'hA1B2_C3D4);
      issue_access(FUNC_READ, 16'hFFFE, 3'd2, 32'h0);
      issue_access(FUNC_WRITE, 16'h0004, 3'd4, {16'h0001, 16'hFFFF});
      issue_access(FUNC_READ, 16'hFFF0, 3'd4, 32'h0);
      wait_idle();
   endtask

   // Equal starts: first data, then second data, then map
   task automatic test_equal_starts();
      program_layout(16'h0040, 9'd8, 16'h0040, 9'd16, 16'h0000, 16'h0040, 9'd4);
      issue_access(FUNC_WRITE, 16'h0046, 3'd4, 32'hCAFE_F00D);
      issue_access(FUNC_READ, 16'h0000, 3'd2, 32'h0);
      issue_access(FUNC_READ, 16'h0044, 3'd4, 32'h0);
      wait_idle();
   endtask

   // Layout larger than the store fails everything and writes nothing; then it is shrunk to fit
   task automatic test_oversized_layout();
      program_layout(16'h0000, 9'd256, 16'h1000, 9'd1, 16'h2000, 16'h3000, 9'd0);
      issue_access(FUNC_WRITE, 16'h0000, 3'd4, 32'hFFFF_FFFF);
      issue_access(FUNC_READ, 16'h0000, 3'd0, 32'h0);
      wait_idle();
      write_csr(REG_SECOND_DATA_LENGTH, 16'd0);
      issue_access(FUNC_READ, 16'h0000, 3'd4, 32'h0);
      issue_access(FUNC_READ, 16'h00FF, 3'd4, 32'h0);
      wait_idle();
   endtask

   // Random traffic over several layouts and idling patterns
   task automatic test_random_traffic();
      int phase, n;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: set_idling(0, 0);
            1: set_idling(72, 0);
            2: set_idling(0, 72);
            default: set_idling(19, 19);
         endcase
         if (phase == 0)
            program_layout(16'h0000, 9'd0, 16'h0000, 9'd128, 16'hFFFF, 16'hFF80, 9'd128);
         else if (phase == 1)
            program_layout(16'hFFFF, 9'd0, 16'hFFFF, 9'd0, 16'h0100, 16'h0000, 9'd256);
         else
            random_layout();
         for (n = 0; n < PHASE_ITEMS; n++) random_access();
         wait_idle();
      end
   endtask

   // Hold the result side off long enough for the input to stall
   task automatic test_output_hold();
      int n;
      set_idling(0, 0);
      random_layout();
      hold_left = 400;
      for (n = 0; n < HOLD_ITEMS; n++) random_access();
      wait_idle();
   endtask

   initial begin
      cfg_first_start  = '0;
      cfg_first_len    = '0;
      cfg_second_start = '0;
      cfg_second_len   = '0;
      cfg_window_start = '0;
      cfg_map_start    = '0;
      cfg_map_len      = '0;
      foreach (store_image[i]) store_image[i] = 8'h00;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cleared_store();
      test_direct_segments();
      test_indirect_window();
      test_address_top();
      test_equal_starts();
      test_oversized_layout();
      test_random_traffic();
      test_output_hold();

      if (awaited_results.size() != 0)
         report_mismatch("results never seen", awaited_results.size(), 0);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/srfim_pkg.sv
hdl/srfim_layout.sv
hdl/srfim_dpath.sv
hdl/srfim_ctrl.sv
hdl/segmented_register_file_indirect_map.sv
dv/tb.sv
